// File: design/particle_force_damp_bounce_step_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the particle step block
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_FORCE_DAMP_BOUNCE_STEP_ASSERT_SVH
`define PARTICLE_FORCE_DAMP_BOUNCE_STEP_ASSERT_SVH

// implication checked on every rising edge outside reset
`define PFDBS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pfdbs: implication failed");

// condition that must never be seen outside reset
`define PFDBS_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("pfdbs: forbidden condition seen");

`endif

// File: design/pfdbs_pkg.sv
// ----------------------------------------------------------------------------
// Particle step package
// Request and result types, register map and shared constants.
// ----------------------------------------------------------------------------
package pfdbs_pkg;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] pointer_x;
		logic signed [31:0] pointer_y;
		logic               pointer_held;
	} in_req_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic               saturated;
	} out_res_t;

	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_REPEL   = 3'd0,
		REG_FALLOFF = 3'd1,
		REG_DAMP    = 3'd2,
		REG_GAIN    = 3'd3,
		REG_TSTEP   = 3'd4
	} reg_idx_t;

	localparam logic        RST_REPEL   = 1'b0;
	localparam logic        RST_FALLOFF = 1'b1;
	localparam logic        RST_DAMP    = 1'b1;
	localparam logic [7:0]  RST_GAIN    = 8'd1;
	localparam logic [24:0] RST_TSTEP   = 25'd503316;

	localparam int ROOT_W = 32;
	localparam int Q1_W   = 25;
	localparam int Q2_W   = 40;
	localparam int Q3_W   = 34;
	localparam int PIPE_LAT = 4 + ROOT_W + Q1_W + 2 + Q2_W + 1 + Q3_W + 5;

	localparam logic [32:0] RECIP_1000 = 33'd4398046512;
	localparam logic [32:0] RECIP_201  = 33'd5470207104;
	localparam logic [33:0] FORCE_CAP  = 34'h2_0000_0000;
	localparam logic [13:0] DIST_SCALE = 14'd10000;
	localparam logic [32:0] DAMP_BIAS  = 33'd200;
	localparam logic signed [35:0] Q_ONE = 36'sh001000000;

endpackage

// File: design/pfdbs_div.sv
// ----------------------------------------------------------------------------
// Pipelined two-lane divider
// Restoring division, one quotient bit per stage, shared divisor, side tag.
// ----------------------------------------------------------------------------
module pfdbs_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 32,
	parameter int Q_W   = 25,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num_a,
	input  logic [NUM_W-1:0] num_b,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo_a,
	output logic [Q_W-1:0]   quo_b,
	output logic [TAG_W-1:0] tag_out
);

	logic             vld_s   [Q_W];
	logic [DEN_W-1:0] den_s   [Q_W];
	logic [DEN_W-1:0] rem_a_s [Q_W];
	logic [DEN_W-1:0] rem_b_s [Q_W];
	logic [Q_W-1:0]   wrk_a_s [Q_W];
	logic [Q_W-1:0]   wrk_b_s [Q_W];
	logic [TAG_W-1:0] tag_s   [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic             vld_p;
		logic [DEN_W-1:0] den_p;
		logic [DEN_W-1:0] rem_a_p;
		logic [DEN_W-1:0] rem_b_p;
		logic [Q_W-1:0]   wa_p;
		logic [Q_W-1:0]   wb_p;
		logic [TAG_W-1:0] tag_p;
		logic [DEN_W:0]   tr_a;
		logic [DEN_W:0]   tr_b;
		logic             ge_a;
		logic             ge_b;

		if (k == 0) begin : g_first
			assign vld_p   = in_valid;
			assign den_p   = den;
			assign rem_a_p = DEN_W'(num_a[NUM_W-1:Q_W]);
			assign rem_b_p = DEN_W'(num_b[NUM_W-1:Q_W]);
			assign wa_p    = num_a[Q_W-1:0];
			assign wb_p    = num_b[Q_W-1:0];
			assign tag_p   = tag_in;
		end else begin : g_next
			assign vld_p   = vld_s[k-1];
			assign den_p   = den_s[k-1];
			assign rem_a_p = rem_a_s[k-1];
			assign rem_b_p = rem_b_s[k-1];
			assign wa_p    = wrk_a_s[k-1];
			assign wb_p    = wrk_b_s[k-1];
			assign tag_p   = tag_s[k-1];
		end

		assign tr_a = {rem_a_p, wa_p[Q_W-1]};
		assign tr_b = {rem_b_p, wb_p[Q_W-1]};
		assign ge_a = (tr_a >= {1'b0, den_p});
		assign ge_b = (tr_b >= {1'b0, den_p});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			den_s[k]   <= den_p;
			rem_a_s[k] <= ge_a ? DEN_W'(tr_a - {1'b0, den_p}) : tr_a[DEN_W-1:0];
			rem_b_s[k] <= ge_b ? DEN_W'(tr_b - {1'b0, den_p}) : tr_b[DEN_W-1:0];
			wrk_a_s[k] <= {wa_p[Q_W-2:0], ge_a};
			wrk_b_s[k] <= {wb_p[Q_W-2:0], ge_b};
			tag_s[k]   <= tag_p;
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign quo_a     = wrk_a_s[Q_W-1];
	assign quo_b     = wrk_b_s[Q_W-1];
	assign tag_out   = tag_s[Q_W-1];

endmodule

// File: design/pfdbs_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one root bit per stage, side tag.
// ----------------------------------------------------------------------------
module pfdbs_sqrt #(
	parameter int ROOT_W = 32,
	parameter int TAG_W  = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [2*ROOT_W-1:0] rad,
	input  logic [TAG_W-1:0]    tag_in,
	output logic                out_valid,
	output logic [ROOT_W-1:0]   root,
	output logic [TAG_W-1:0]    tag_out
);

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	logic              vld_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] rt_s   [ROOT_W];
	logic [RAD_W-1:0]  nw_s   [ROOT_W];
	logic [TAG_W-1:0]  tag_s  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              vld_p;
		logic [REM_W-1:0]  rem_p;
		logic [ROOT_W-1:0] rt_p;
		logic [RAD_W-1:0]  nw_p;
		logic [TAG_W-1:0]  tag_p;
		logic [REM_W+1:0]  sh;
		logic [REM_W+1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_p = in_valid;
			assign rem_p = '0;
			assign rt_p  = '0;
			assign nw_p  = rad;
			assign tag_p = tag_in;
		end else begin : g_next
			assign vld_p = vld_s[k-1];
			assign rem_p = rem_s[k-1];
			assign rt_p  = rt_s[k-1];
			assign nw_p  = nw_s[k-1];
			assign tag_p = tag_s[k-1];
		end

		assign sh    = {rem_p, nw_p[RAD_W-1 -: 2]};
		assign trial = {2'b00, rt_p, 2'b01};
		assign ge    = (sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? REM_W'(sh - trial) : sh[REM_W-1:0];
			rt_s[k]  <= {rt_p[ROOT_W-2:0], ge};
			nw_s[k]  <= {nw_p[RAD_W-3:0], 2'b00};
			tag_s[k] <= tag_p;
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign root      = rt_s[ROOT_W-1];
	assign tag_out   = tag_s[ROOT_W-1];

endmodule

// File: design/particle_force_damp_bounce_step.sv
// ----------------------------------------------------------------------------
// Particle force, damping, bounce and Euler step
// Fully pipelined Q8.24 update of one 2-D particle per clock.
// ----------------------------------------------------------------------------
// Channel   Signals                               Transfer
// request   start, busy, req                      start high, busy low
// result    done, res                             done high, one cycle only
// config    psel, penable, pwrite, paddr, pwdata  access phase, pready high
//           prdata, pready                        read data combinational
//
// One request per cycle; busy stays low.
// The pipeline includes the square root (32 stages) and
// the three dividers (25, 40 and 34 stages, one quotient bit each).
// Reset clears valid bits and loads register defaults; data stages hold none.
// The result side has no stall: every result leaves on its done cycle.
// ----------------------------------------------------------------------------
module particle_force_damp_bounce_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  pfdbs_pkg::in_req_t           req,
	output logic                         done,
	output pfdbs_pkg::out_res_t          res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pfdbs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	import pfdbs_pkg::*;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               apply;
		logic               negx;
		logic               negy;
		logic               flag;
	} track_t;

	typedef struct packed {
		track_t      trk;
		logic [31:0] ax;
		logic [31:0] ay;
	} sq_tag_t;

	typedef struct packed {
		track_t      trk;
		logic [31:0] r;
	} d1_tag_t;

	typedef struct packed {
		track_t      trk;
		logic [22:0] f0x;
		logic [22:0] f0y;
		logic        capx;
		logic        capy;
		logic [45:0] d3;
	} d2_tag_t;

	typedef struct packed {
		track_t      trk;
		logic [22:0] f0x;
		logic [22:0] f0y;
		logic        capx;
		logic        capy;
	} d3_tag_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               ovf;
	} sat_t;

	function automatic logic signed [35:0] sx36(input logic [31:0] v);
		sx36 = $signed({{4{v[31]}}, v});
	endfunction

	function automatic sat_t sat32(input logic signed [35:0] v);
		sat_t s;
		s.ovf = !((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111));
		if (s.ovf) begin
			s.val = v[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			s.val = v[31:0];
		end
		return s;
	endfunction

	// config registers
	logic        repel_q;
	logic        falloff_q;
	logic        damp_q;
	logic [7:0]  gain_q;
	logic [24:0] tstep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repel_q   <= RST_REPEL;
			falloff_q <= RST_FALLOFF;
			damp_q    <= RST_DAMP;
			gain_q    <= RST_GAIN;
			tstep_q   <= RST_TSTEP;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_REPEL:   repel_q   <= pwdata[0];
				REG_FALLOFF: falloff_q <= pwdata[0];
				REG_DAMP:    damp_q    <= pwdata[0];
				REG_GAIN:    gain_q    <= pwdata[7:0];
				REG_TSTEP:   tstep_q   <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_REPEL:   prdata = {31'b0, repel_q};
			REG_FALLOFF: prdata = {31'b0, falloff_q};
			REG_DAMP:    prdata = {31'b0, damp_q};
			REG_GAIN:    prdata = {24'b0, gain_q};
			REG_TSTEP:   prdata = {7'b0, tstep_q};
			default:     prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign busy   = 1'b0;

	// stage 1: capture request
	in_req_t req_s1;
	logic    v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;
	end

	// stage 2: offset to pointer
	sat_t        dx_c;
	sat_t        dy_c;
	track_t      trk_c2;
	logic [31:0] ax_c;
	logic [31:0] ay_c;

	always_comb begin
		dx_c = sat32(sx36(req_s1.pointer_x) - sx36(req_s1.pos_x));
		dy_c = sat32(sx36(req_s1.pointer_y) - sx36(req_s1.pos_y));
		ax_c = dx_c.val[31] ? (~dx_c.val + 32'd1) : dx_c.val;
		ay_c = dy_c.val[31] ? (~dy_c.val + 32'd1) : dy_c.val;
		trk_c2.px    = req_s1.pos_x;
		trk_c2.py    = req_s1.pos_y;
		trk_c2.vx    = req_s1.vel_x;
		trk_c2.vy    = req_s1.vel_y;
		trk_c2.apply = req_s1.pointer_held;
		trk_c2.negx  = dx_c.val[31];
		trk_c2.negy  = dy_c.val[31];
		trk_c2.flag  = req_s1.pointer_held && (dx_c.ovf || dy_c.ovf);
	end

	track_t      trk_s2;
	logic [31:0] ax_s2;
	logic [31:0] ay_s2;
	logic        v_s2;

	// stage 3: squares
	track_t      trk_s3;
	logic [31:0] ax_s3;
	logic [31:0] ay_s3;
	logic [63:0] sqx_s3;
	logic [63:0] sqy_s3;
	logic        v_s3;

	// stage 4: squared distance
	sq_tag_t     sqt_s4;
	logic [63:0] n_s4;
	logic        v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		trk_s2     <= trk_c2;
		ax_s2      <= ax_c;
		ay_s2      <= ay_c;
		trk_s3     <= trk_s2;
		ax_s3      <= ax_s2;
		ay_s3      <= ay_s2;
		sqx_s3     <= ax_s2 * ax_s2;
		sqy_s3     <= ay_s2 * ay_s2;
		sqt_s4.trk <= trk_s3;
		sqt_s4.ax  <= ax_s3;
		sqt_s4.ay  <= ay_s3;
		n_s4       <= sqx_s3 + sqy_s3;
	end

	// distance
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	sq_tag_t           sq_tag;

	pfdbs_sqrt #(
		.ROOT_W (ROOT_W),
		.TAG_W  ($bits(sq_tag_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.rad       (n_s4),
		.tag_in    (sqt_s4),
		.out_valid (sq_vld),
		.root      (sq_root),
		.tag_out   (sq_tag)
	);

	// unit vector
	d1_tag_t         d1_in;
	logic            d1_vld;
	logic [Q1_W-1:0] ux;
	logic [Q1_W-1:0] uy;
	d1_tag_t         d1_out;

	assign d1_in.trk = sq_tag.trk;
	assign d1_in.r   = sq_root;

	pfdbs_div #(
		.NUM_W (56),
		.DEN_W (32),
		.Q_W   (Q1_W),
		.TAG_W ($bits(d1_tag_t))
	) u_div_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_vld),
		.num_a     ({sq_tag.ax, 24'b0}),
		.num_b     ({sq_tag.ay, 24'b0}),
		.den       (sq_root),
		.tag_in    (d1_in),
		.out_valid (d1_vld),
		.quo_a     (ux),
		.quo_b     (uy),
		.tag_out   (d1_out)
	);

	// stage 5: gain and scaled distance
	logic [32:0] gx_p;
	logic [32:0] gy_p;
	track_t      trk_c5;

	always_comb begin
		gx_p         = gain_q * ux;
		gy_p         = gain_q * uy;
		trk_c5       = d1_out.trk;
		trk_c5.apply = d1_out.trk.apply && (d1_out.r != 32'd0);
	end

	track_t      trk_s5;
	logic [31:0] gx_s5;
	logic [31:0] gy_s5;
	logic [31:0] r_s5;
	logic [45:0] d3_s5;
	logic        v_s5;

	// stage 6: plain force and overflow test
	logic [64:0] f0x_p;
	logic [64:0] f0y_p;

	assign f0x_p = gx_s5 * RECIP_1000;
	assign f0y_p = gy_s5 * RECIP_1000;

	d2_tag_t     d2t_s6;
	logic [31:0] gx_s6;
	logic [31:0] gy_s6;
	logic [31:0] r_s6;
	logic        v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s5 <= d1_vld;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		trk_s5      <= trk_c5;
		gx_s5       <= gx_p[31:0];
		gy_s5       <= gy_p[31:0];
		r_s5        <= d1_out.r;
		d3_s5       <= d1_out.r * DIST_SCALE;
		d2t_s6.trk  <= trk_s5;
		d2t_s6.f0x  <= f0x_p[64:42];
		d2t_s6.f0y  <= f0y_p[64:42];
		d2t_s6.capx <= ({16'b0, gx_s5} >= {r_s5, 16'b0});
		d2t_s6.capy <= ({16'b0, gy_s5} >= {r_s5, 16'b0});
		d2t_s6.d3   <= d3_s5;
		gx_s6       <= gx_s5;
		gy_s6       <= gy_s5;
		r_s6        <= r_s5;
	end

	// first falloff quotient
	logic            d2_vld;
	logic [Q2_W-1:0] tx;
	logic [Q2_W-1:0] ty;
	d2_tag_t         d2_out;

	pfdbs_div #(
		.NUM_W (56),
		.DEN_W (32),
		.Q_W   (Q2_W),
		.TAG_W ($bits(d2_tag_t))
	) u_div_fall (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.num_a     ({gx_s6, 24'b0}),
		.num_b     ({gy_s6, 24'b0}),
		.den       (r_s6),
		.tag_in    (d2t_s6),
		.out_valid (d2_vld),
		.quo_a     (tx),
		.quo_b     (ty),
		.tag_out   (d2_out)
	);

	// stage 7: second overflow test
	d3_tag_t         d3t_s7;
	logic [Q2_W-1:0] tx_s7;
	logic [Q2_W-1:0] ty_s7;
	logic [45:0]     d3_s7;
	logic            v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		d3t_s7.trk  <= d2_out.trk;
		d3t_s7.f0x  <= d2_out.f0x;
		d3t_s7.f0y  <= d2_out.f0y;
		d3t_s7.capx <= d2_out.capx || ({16'b0, tx} >= {d2_out.d3, 10'b0});
		d3t_s7.capy <= d2_out.capy || ({16'b0, ty} >= {d2_out.d3, 10'b0});
		tx_s7       <= tx;
		ty_s7       <= ty;
		d3_s7       <= d2_out.d3;
	end

	// second falloff quotient
	logic            d3_vld;
	logic [Q3_W-1:0] fqx;
	logic [Q3_W-1:0] fqy;
	d3_tag_t         d3_out;

	pfdbs_div #(
		.NUM_W (64),
		.DEN_W (46),
		.Q_W   (Q3_W),
		.TAG_W ($bits(d3_tag_t))
	) u_div_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.num_a     ({tx_s7, 24'b0}),
		.num_b     ({ty_s7, 24'b0}),
		.den       (d3_s7),
		.tag_in    (d3t_s7),
		.out_valid (d3_vld),
		.quo_a     (fqx),
		.quo_b     (fqy),
		.tag_out   (d3_out)
	);

	// stage 8: apply force
	logic [33:0]        fsel_x;
	logic [33:0]        fsel_y;
	logic signed [35:0] vsum_x;
	logic signed [35:0] vsum_y;
	sat_t               vs_x;
	sat_t               vs_y;

	always_comb begin
		if (!falloff_q) begin
			fsel_x = 34'(d3_out.f0x);
			fsel_y = 34'(d3_out.f0y);
		end else begin
			fsel_x = (d3_out.capx || fqx > FORCE_CAP) ? FORCE_CAP : fqx;
			fsel_y = (d3_out.capy || fqy > FORCE_CAP) ? FORCE_CAP : fqy;
		end
		vsum_x = sx36(d3_out.trk.vx);
		vsum_y = sx36(d3_out.trk.vy);
		if (d3_out.trk.apply) begin
			if (d3_out.trk.negx ^ repel_q) begin
				vsum_x = vsum_x - $signed({2'b00, fsel_x});
			end else begin
				vsum_x = vsum_x + $signed({2'b00, fsel_x});
			end
			if (d3_out.trk.negy ^ repel_q) begin
				vsum_y = vsum_y - $signed({2'b00, fsel_y});
			end else begin
				vsum_y = vsum_y + $signed({2'b00, fsel_y});
			end
		end
		vs_x = sat32(vsum_x);
		vs_y = sat32(vsum_y);
	end

	logic signed [31:0] vx_s8;
	logic signed [31:0] vy_s8;
	logic signed [31:0] px_s8;
	logic signed [31:0] py_s8;
	logic               flag_s8;
	logic               v_s8;

	// stage 9: damping quotient
	logic [31:0] mx_c;
	logic [31:0] my_c;
	logic [65:0] cx_p;
	logic [65:0] cy_p;

	always_comb begin
		mx_c = vx_s8[31] ? (~vx_s8 + 32'd1) : vx_s8;
		my_c = vy_s8[31] ? (~vy_s8 + 32'd1) : vy_s8;
		cx_p = ({1'b0, mx_c} + DAMP_BIAS) * RECIP_201;
		cy_p = ({1'b0, my_c} + DAMP_BIAS) * RECIP_201;
	end

	logic [31:0]        mx_s9;
	logic [31:0]        my_s9;
	logic [24:0]        cx_s9;
	logic [24:0]        cy_s9;
	logic               nx_s9;
	logic               ny_s9;
	logic signed [31:0] px_s9;
	logic signed [31:0] py_s9;
	logic               flag_s9;
	logic               v_s9;

	// stage 10: damp and bounce
	logic [31:0]        magx;
	logic [31:0]        magy;
	logic signed [35:0] vdx;
	logic signed [35:0] vdy;
	sat_t               bx;
	sat_t               by;

	always_comb begin
		magx = damp_q ? (mx_s9 - 32'(cx_s9)) : mx_s9;
		magy = damp_q ? (my_s9 - 32'(cy_s9)) : my_s9;
		vdx  = nx_s9 ? (36'sd0 - $signed({4'b0, magx})) : $signed({4'b0, magx});
		vdy  = ny_s9 ? (36'sd0 - $signed({4'b0, magy})) : $signed({4'b0, magy});
		if ((sx36(px_s9) < -Q_ONE && vdx < 0) || (sx36(px_s9) > Q_ONE && vdx > 0)) begin
			bx = sat32(36'sd0 - vdx);
		end else begin
			bx = sat32(vdx);
		end
		if ((sx36(py_s9) < -Q_ONE && vdy < 0) || (sx36(py_s9) > Q_ONE && vdy > 0)) begin
			by = sat32(36'sd0 - vdy);
		end else begin
			by = sat32(vdy);
		end
	end

	logic signed [31:0] vx_s10;
	logic signed [31:0] vy_s10;
	logic signed [31:0] px_s10;
	logic signed [31:0] py_s10;
	logic               flag_s10;
	logic               v_s10;

	// stage 11: step length
	logic [31:0] amx;
	logic [31:0] amy;
	logic [56:0] advx_p;
	logic [56:0] advy_p;

	always_comb begin
		amx    = vx_s10[31] ? (~vx_s10 + 32'd1) : vx_s10;
		amy    = vy_s10[31] ? (~vy_s10 + 32'd1) : vy_s10;
		advx_p = amx * tstep_q;
		advy_p = amy * tstep_q;
	end

	logic [31:0]        advx_s11;
	logic [31:0]        advy_s11;
	logic signed [31:0] vx_s11;
	logic signed [31:0] vy_s11;
	logic signed [31:0] px_s11;
	logic signed [31:0] py_s11;
	logic               flag_s11;
	logic               v_s11;

	// stage 12: integrate
	sat_t npx;
	sat_t npy;

	always_comb begin
		npx = sat32(vx_s11[31] ? (sx36(px_s11) - $signed({4'b0, advx_s11}))
			: (sx36(px_s11) + $signed({4'b0, advx_s11})));
		npy = sat32(vy_s11[31] ? (sx36(py_s11) - $signed({4'b0, advy_s11}))
			: (sx36(py_s11) + $signed({4'b0, advy_s11})));
	end

	out_res_t res_s12;
	logic     v_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			v_s8  <= d3_vld;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		vx_s8     <= vs_x.val;
		vy_s8     <= vs_y.val;
		px_s8     <= d3_out.trk.px;
		py_s8     <= d3_out.trk.py;
		flag_s8   <= d3_out.trk.flag || (d3_out.trk.apply && (vs_x.ovf || vs_y.ovf));

		mx_s9     <= mx_c;
		my_s9     <= my_c;
		cx_s9     <= cx_p[64:40];
		cy_s9     <= cy_p[64:40];
		nx_s9     <= vx_s8[31];
		ny_s9     <= vy_s8[31];
		px_s9     <= px_s8;
		py_s9     <= py_s8;
		flag_s9   <= flag_s8;

		vx_s10    <= bx.val;
		vy_s10    <= by.val;
		px_s10    <= px_s9;
		py_s10    <= py_s9;
		flag_s10  <= flag_s9 || bx.ovf || by.ovf;

		advx_s11  <= advx_p[55:24];
		advy_s11  <= advy_p[55:24];
		vx_s11    <= vx_s10;
		vy_s11    <= vy_s10;
		px_s11    <= px_s10;
		py_s11    <= py_s10;
		flag_s11  <= flag_s10;

		res_s12.new_pos_x <= npx.val;
		res_s12.new_pos_y <= npy.val;
		res_s12.new_vel_x <= vx_s11;
		res_s12.new_vel_y <= vy_s11;
		res_s12.saturated <= flag_s11 || npx.ovf || npy.ovf;
	end

	assign done = v_s12;
	assign res  = res_s12;

endmodule

// File: design/pfdbs_checker.sv
// ----------------------------------------------------------------------------
// Particle step port checker
// Watches the request, result and register ports of the top level.
// ----------------------------------------------------------------------------
`include "particle_force_damp_bounce_step_assert.svh"

module pfdbs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [pfdbs_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                  pwdata,
	input logic [31:0]                  prdata
);

	import pfdbs_pkg::*;

	`PFDBS_ASSERT_NEVER(a_never_busy, clk, arst_n, busy)

	`PFDBS_ASSERT_IMP(a_req_gives_res, clk, arst_n, start && !busy, ##PIPE_LAT done)

	`PFDBS_ASSERT_IMP(a_res_has_req, clk, arst_n, done, $past(start && !busy, PIPE_LAT))

	`PFDBS_ASSERT_IMP(a_gain_readback, clk, arst_n, psel && penable && pwrite && paddr[4:2] == REG_GAIN ##1 paddr[4:2] == REG_GAIN, prdata == {24'b0, $past(pwdata[7:0])})

endmodule

bind particle_force_damp_bounce_step pfdbs_checker u_pfdbs_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Particle step testbench
// Streams particle requests through the block under several register
// settings, predicts each updated particle and compares every result field.
// ----------------------------------------------------------------------------
module testbench;
	import pfdbs_pkg::*;

	localparam longint ONE_Q  = 64'sd16777216;
	localparam longint MAX_Q  = 64'sd2147483647;
	localparam longint MIN_Q  = -64'sd2147483648;
	localparam longint unsigned CAP_F = 64'd8589934592;
	localparam int CYCLE_LIMIT = 400000;

	logic clk, arst_n, start, busy, done, psel, penable, pwrite, pready;
	in_req_t req;
	out_res_t res;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	particle_force_damp_bounce_step i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	bit m_repel, m_falloff, m_damp;
	longint unsigned m_gain, m_tstep;

	in_req_t pending_reqs[$];
	out_res_t expected_particles[$];
	int errors = 0;
	int cycles = 0;
	int sent = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic longint clamp32(longint v, inout bit f);
		if (v > MAX_Q) begin
			f = 1;
			return MAX_Q;
		end
		if (v < MIN_Q) begin
			f = 1;
			return MIN_Q;
		end
		return v;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint apply_sign(longint unsigned m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned pull_force(longint unsigned a, longint unsigned r);
		longint unsigned u, g, t, f;
		u = (a << 24) / r;
		g = m_gain * u;
		if (!m_falloff) return g / 1000;
		t = (g << 24) / r;
		if (t >= (64'd1 << 40)) return CAP_F;
		f = (t << 24) / (64'd10000 * r);
		return f > CAP_F ? CAP_F : f;
	endfunction

	function automatic longint reflect(longint p, longint v, inout bit f);
		if ((p < -ONE_Q && v < 0) || (p > ONE_Q && v > 0)) return clamp32(-v, f);
		return v;
	endfunction

	function automatic longint integrate(longint p, longint v, inout bit f);
		longint unsigned m;
		m = (mag(v) * m_tstep) >> 24;
		return clamp32(p + apply_sign(m, v < 0), f);
	endfunction

	function automatic out_res_t step_particle(in_req_t q);
		out_res_t o;
		bit f;
		longint px, py, vx, vy, dx, dy;
		longint unsigned ax, ay, r;
		f = 0;
		px = q.pos_x;
		py = q.pos_y;
		vx = q.vel_x;
		vy = q.vel_y;
		if (q.pointer_held) begin
			dx = clamp32(longint'(q.pointer_x) - px, f);
			dy = clamp32(longint'(q.pointer_y) - py, f);
			ax = mag(dx);
			ay = mag(dy);
			r = root64(ax * ax + ay * ay);
			if (r != 0) begin
				vx = clamp32(vx + apply_sign(pull_force(ax, r), (dx < 0) != m_repel), f);
				vy = clamp32(vy + apply_sign(pull_force(ay, r), (dy < 0) != m_repel), f);
			end
		end
		if (m_damp) begin
			vx = apply_sign(mag(vx) * 200 / 201, vx < 0);
			vy = apply_sign(mag(vy) * 200 / 201, vy < 0);
		end
		vx = reflect(px, vx, f);
		vy = reflect(py, vy, f);
		o.new_pos_x = integrate(px, vx, f);
		o.new_pos_y = integrate(py, vy, f);
		o.new_vel_x = vx;
		o.new_vel_y = vy;
		o.saturated = f;
		return o;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (pending_reqs.size() != 0 && !(start && busy) &&
					(sent >= 600 && sent < 950 || $urandom_range(0, 99) >= 36)) begin
				req <= pending_reqs.pop_front();
				start <= 1'b1;
				sent++;
			end else if (!(start && busy)) begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_res_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL particle_force_damp_bounce_step");
			$finish;
		end
		if (arst_n) begin
			if (start && !busy) expected_particles.push_back(step_particle(req));
			if (done) begin
				if (expected_particles.size() == 0) begin
					$error("unexpected result");
					errors++;
				end else begin
					e = expected_particles.pop_front();
					if (res.new_pos_x !== e.new_pos_x) begin
						$error("new_pos_x exp %h got %h", e.new_pos_x, res.new_pos_x);
						errors++;
					end
					if (res.new_pos_y !== e.new_pos_y) begin
						$error("new_pos_y exp %h got %h", e.new_pos_y, res.new_pos_y);
						errors++;
					end
					if (res.new_vel_x !== e.new_vel_x) begin
						$error("new_vel_x exp %h got %h", e.new_vel_x, res.new_vel_x);
						errors++;
					end
					if (res.new_vel_y !== e.new_vel_y) begin
						$error("new_vel_y exp %h got %h", e.new_vel_y, res.new_vel_y);
						errors++;
					end
					if (res.saturated !== e.saturated) begin
						$error("saturated exp %b got %b", e.saturated, res.saturated);
						errors++;
					end
				end
			end
		end
	end

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || start || expected_particles.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_REPEL: m_repel = v[0];
			REG_FALLOFF: m_falloff = v[0];
			REG_DAMP: m_damp = v[0];
			REG_GAIN: m_gain = v[7:0];
			REG_TSTEP: m_tstep = v[24:0];
			default: ;
		endcase
	endtask

	task automatic configure(bit rp, bit fo, bit dm, logic [7:0] g, logic [24:0] ts);
		write_reg(REG_REPEL, rp);
		write_reg(REG_FALLOFF, fo);
		write_reg(REG_DAMP, dm);
		write_reg(REG_GAIN, g);
		write_reg(REG_TSTEP, ts);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'(int'($urandom_range(0, 2048)) - 1024);
			default: return 32'(int'($urandom_range(0, 67108864)) - 33554432);
		endcase
	endfunction

	task automatic add_req(logic [31:0] px, py, vx, vy, mx, my, logic held);
		in_req_t q;
		q.pos_x = px;
		q.pos_y = py;
		q.vel_x = vx;
		q.vel_y = vy;
		q.pointer_x = mx;
		q.pointer_y = my;
		q.pointer_held = held;
		pending_reqs.push_back(q);
	endtask

	task automatic add_random(int n);
		logic [31:0] px, py;
		for (int i = 0; i < n; i++) begin
			px = rand_value();
			py = rand_value();
			case ($urandom_range(0, 5))
				0: add_req(px, py, rand_value(), rand_value(), px, py, 1'b1);
				1: add_req(px, py, rand_value(), rand_value(), rand_value(), rand_value(),
					$urandom_range(0, 1));
				default: add_req(px, py, rand_value(), rand_value(),
					px + 32'(int'($urandom_range(0, 8388608)) - 4194304),
					py + 32'(int'($urandom_range(0, 8388608)) - 4194304), 1'b1);
			endcase
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		req = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		m_repel = RST_REPEL;
		m_falloff = RST_FALLOFF;
		m_damp = RST_DAMP;
		m_gain = RST_GAIN;
		m_tstep = RST_TSTEP;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		add_req(0, 0, 0, 0, 0, 0, 1'b0);
		add_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 1'b1);
		add_req(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 1'b1);
		add_req(32'h01000000, 32'hff000000, 32'h00100000, 32'hfff00000,
			32'h01000000, 32'hff000000, 1'b1);
		add_req(32'h02000000, 32'hfe000000, 32'h00100000, 32'hfff00000, 0, 0, 1'b0);
		add_req(32'hfe000000, 32'h02000000, 32'h80000000, 32'h7fffffff, 0, 0, 1'b0);
		add_req(32'h01000001, 32'hfeffffff, 1, 32'hffffffff, 0, 0, 1'b0);
		add_req(0, 0, 0, 0, 1, 0, 1'b1);
		add_req(0, 0, 0, 0, 0, 32'hffffffff, 1'b1);
		add_req(0, 0, 32'h7fff0000, 0, 32'h00010000, 0, 1'b1);
		add_req(32'h00800000, 32'h00400000, 32'h00200000, 32'hffe00000,
			32'h00000100, 32'hff000000, 1'b1);
		add_req(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
			32'haaaaaaaa, 32'h55555555, 1'b1);
		add_random(280);
		wait_idle();

		configure(1'b1, 1'b0, 1'b0, 8'd255, 25'd16777216);
		add_random(280);
		wait_idle();
		configure(1'b0, 1'b1, 1'b1, 8'd0, 25'd0);
		add_random(250);
		wait_idle();
		configure(1'b1, 1'b1, 1'b0, 8'd255, 25'h1ffffff);
		add_random(300);
		wait_idle();
		configure(1'b0, 1'b0, 1'b1, 8'd1, 25'd503316);
		add_random(250);
		wait_idle();
		configure($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
			$urandom_range(0, 255), $urandom_range(0, 16777216));
		add_random(330);
		wait_idle();
		repeat (PIPE_LAT + 20) @(posedge clk);

		if (errors == 0)
			$display("PASS particle_force_damp_bounce_step");
		else
			$display("FAIL particle_force_damp_bounce_step");
		$finish;
	end
endmodule
